// File: design/stbs_pkg.sv
package stbs_pkg;

	// Index width of the item fields and word width of the table
	localparam int IDX_W  = 10;
	localparam int WORD_W = 32;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SEARCH = 1'b1
	} op_t;

	typedef struct packed {
		op_t                       op;
		logic [IDX_W-1:0]          write_index;
		logic signed [WORD_W-1:0]  write_data;
		logic signed [WORD_W-1:0]  search_key;
		logic [IDX_W-1:0]          range_first;
		logic [IDX_W-1:0]          range_last;
	} in_item_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] position;
	} out_item_t;

	// Controller to datapath commands
	typedef struct packed {
		logic wr;       // store write item into the table
		logic load;     // capture key and range of a search item
		logic first;    // issue first probe at the range midpoint
		logic step;     // narrow range after compare and issue next probe
		logic res_ld;   // load result register
		logic res_hit;  // result is a match
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic empty;       // current range is empty
		logic eq;          // probed word equals key
		logic next_empty;  // narrowed range would be empty
	} dp_sts_t;

endpackage

// File: design/sorted_table_binary_search.sv
// Channel  Signals                      Payload     Transfer
// input    in_valid, in_ready, in_data  in_item_t   in_valid && in_ready
// output   out_valid, out_ready,        out_item_t  out_valid && out_ready
//          out_data
//
// A write item yields no result.
// A search makes P probes (at most 11 for a 1024-entry range), one probe
// per cycle through the table's registered read.
// The next item is taken once the result sits in the output register.
// A result waiting on out_ready holds the next search's result back.
// Reset clears control only; table contents are undefined until written.
module sorted_table_binary_search
	import stbs_pkg::*;
#(
	parameter int DEPTH = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	stbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_op     (in_data.op),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	stbs_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule

// File: design/stbs_ram.sv
module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/stbs_ctrl.sv
module stbs_ctrl
	import stbs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  op_t     in_op,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_START,
		S_CMP,
		S_DONE
	} state_t;

	state_t state_q;
	logic   hit_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Command decode
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_op == OP_WRITE) begin
						cmd.wr = 1'b1;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			S_START: begin
				cmd.first = !sts.empty;
			end
			S_CMP: begin
				cmd.step = !sts.eq && !sts.next_empty;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.res_ld  = 1'b1;
					cmd.res_hit = hit_q;
				end
			end
		endcase
	end

	// State and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_op == OP_SEARCH) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					if (sts.empty) begin
						hit_q   <= 1'b0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (sts.eq) begin
						hit_q   <= 1'b1;
						state_q <= S_DONE;
					end else if (sts.next_empty) begin
						hit_q   <= 1'b0;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (cmd.res_ld) begin
						state_q <= S_IDLE;
					end
				end
			endcase

			if (cmd.res_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A result never overwrites one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_ld |-> (!out_valid_q || out_ready))
		else $error("result loaded over pending transfer");

	a_res_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_ld |=> out_valid_q)
		else $error("loaded result not presented");

	// Input side is closed while a search is in flight
	a_busy_closed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !in_ready ##1 !in_ready)
		else $error("input accepted during search");

endmodule

// File: design/stbs_dpath.sv
module stbs_dpath
	import stbs_pkg::*;
#(
	parameter int DEPTH = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_data,
	input  dp_cmd_t   cmd,
	output dp_sts_t   sts,
	output out_item_t out_data
);

	localparam int AW = $clog2(DEPTH);

	logic signed [IDX_W+1:0]  lo_q;
	logic signed [IDX_W+1:0]  hi_q;
	logic signed [WORD_W-1:0] key_q;
	logic [IDX_W-1:0]         mid_q;
	logic                     rng_q;
	logic                     found_q;
	logic [IDX_W-1:0]         position_q;

	logic                     we;
	logic [WORD_W-1:0]        rdata;
	logic signed [WORD_W-1:0] word;
	logic                     lt;
	logic signed [IDX_W+1:0]  mid_p1;
	logic signed [IDX_W+1:0]  mid_m1;
	logic signed [IDX_W+1:0]  sum_first;
	logic signed [IDX_W+1:0]  sum_up;
	logic signed [IDX_W+1:0]  sum_dn;
	logic [IDX_W-1:0]         mid_first;
	logic [IDX_W-1:0]         mid_up;
	logic [IDX_W-1:0]         mid_dn;
	logic [IDX_W-1:0]         rd_idx;
	logic                     re;

	function automatic logic in_table(input logic [IDX_W-1:0] idx);
		in_table = (32'(idx) < DEPTH);
	endfunction

	// Table store; indexes at or above DEPTH are dropped on write
	assign we = cmd.wr && in_table(in_data.write_index);

	stbs_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (AW'(in_data.write_index)),
		.wdata (in_data.write_data),
		.re    (re),
		.raddr (AW'(rd_idx)),
		.rdata (rdata)
	);

	// Compare probed word against key; out-of-table probes read zero
	assign word = rng_q ? $signed(rdata) : '0;
	assign lt   = (word < key_q);

	// Candidate midpoints for both outcomes, ready before the compare settles
	assign mid_p1    = $signed({2'b00, mid_q}) + 12'sd1;
	assign mid_m1    = $signed({2'b00, mid_q}) - 12'sd1;
	assign sum_first = lo_q + hi_q;
	assign sum_up    = mid_p1 + hi_q;
	assign sum_dn    = lo_q + mid_m1;
	assign mid_first = sum_first[IDX_W:1];
	assign mid_up    = sum_up[IDX_W:1];
	assign mid_dn    = sum_dn[IDX_W:1];

	assign rd_idx = cmd.first ? mid_first : (lt ? mid_up : mid_dn);
	assign re     = cmd.first || cmd.step;

	assign sts.empty      = (lo_q > hi_q);
	assign sts.eq         = (word == key_q);
	assign sts.next_empty = lt ? (mid_p1 > hi_q) : (mid_m1 < lo_q);

	// Search registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lo_q  <= $signed({2'b00, in_data.range_first});
			hi_q  <= $signed({2'b00, in_data.range_last});
			key_q <= in_data.search_key;
		end
		if (cmd.first) begin
			mid_q <= mid_first;
			rng_q <= in_table(mid_first);
		end
		if (cmd.step) begin
			if (lt) begin
				lo_q  <= mid_p1;
				mid_q <= mid_up;
				rng_q <= in_table(mid_up);
			end else begin
				hi_q  <= mid_m1;
				mid_q <= mid_dn;
				rng_q <= in_table(mid_dn);
			end
		end
		if (cmd.res_ld) begin
			found_q    <= cmd.res_hit;
			position_q <= cmd.res_hit ? mid_q : '0;
		end
	end

	assign out_data.found    = found_q;
	assign out_data.position = position_q;

	// Every probe lies inside the current range
	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.first || cmd.step) |=>
			(lo_q <= $signed({2'b00, mid_q}) && $signed({2'b00, mid_q}) <= hi_q))
		else $error("probe outside search range");

	// A step is only taken when the narrowed range is non-empty
	a_step_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> (lo_q <= hi_q))
		else $error("step into empty range");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.res_ld && !cmd.res_hit) |=> (!found_q && position_q == '0))
		else $error("miss result not cleared");

endmodule
